// ===== rtl/tspe_pkg.sv =====
package tspe_pkg;

    // Field and register widths
    localparam int POS_W      = 6;
    localparam int CNT_W      = 4;
    localparam int CTR_W      = 5;
    localparam int MODE_W     = 3;
    localparam int RND_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;
    localparam int PC_W       = 4;

    // Track limits; register writes saturate here
    localparam int MAX_STEPS       = 64;
    localparam int MAX_PROGRESSION = 15;

    // Direction modes; code 7 falls to the plain move-and-wrap rule
    typedef logic [MODE_W-1:0] t_mode;
    localparam t_mode MODE_FWD      = 3'd0;
    localparam t_mode MODE_BACK     = 3'd1;
    localparam t_mode MODE_PINGPONG = 3'd2;
    localparam t_mode MODE_PENDULUM = 3'd3;
    localparam t_mode MODE_RND_DIR  = 3'd4;
    localparam t_mode MODE_RND_STEP = 3'd5;
    localparam t_mode MODE_RND_MIX  = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FWD_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_JB_COUNT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RPL_COUNT  = 3'd5;

    // Mixed random thresholds on the random byte
    localparam logic [RND_W-1:0] RND_MIX_HALF    = 8'h80;
    localparam logic [RND_W-1:0] RND_MIX_QUARTER = 8'h40;

    // Register reset values
    localparam logic [POS_W-1:0] LAST_STEP_RST = 6'd15;

    typedef struct packed {
        t_mode             mode;
        logic [POS_W-1:0]  loop_start;
        logic [POS_W-1:0]  last_step;
        logic [CNT_W-1:0]  fwd_count;
        logic [CNT_W-1:0]  jb_count;
        logic [CNT_W-1:0]  rpl_count;
    } t_cfg;

    // Datapath operations
    typedef enum logic [2:0] {
        DP_NOP         = 3'd0,
        DP_FWD_TICK    = 3'd1,
        DP_MOVE_REV    = 3'd2,
        DP_REPLAY_TICK = 3'd3,
        DP_MOVE_FWD    = 3'd4,
        DP_RESET_POS   = 3'd5,
        DP_CLR_FIRST   = 3'd6
    } t_dp_op;

    // Jump conditions
    typedef enum logic [3:0] {
        C_ALWAYS      = 4'd0,
        C_NO_XFER     = 4'd1,
        C_IS_RESET    = 4'd2,
        C_IS_FIRST    = 4'd3,
        C_WRAP_REQ    = 4'd4,
        C_FWD_HOLD    = 4'd5,
        C_JC_ZERO     = 4'd6,
        C_JC_MORE     = 4'd7,
        C_REPLAY_HOLD = 4'd8,
        C_OUT_BUSY    = 4'd9
    } t_cond;

    // Control word
    typedef struct packed {
        logic              take;
        logic              emit;
        t_dp_op            op;
        t_cond             cond;
        logic [PC_W-1:0]   target;
    } t_uword;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic is_reset;
        logic is_first;
        logic wrap_req;
        logic fwd_hold;
        logic jc_zero;
        logic jc_more;
        logic replay_hold;
    } t_dp_status;

endpackage

// ===== rtl/tspe_useq.sv =====
module tspe_useq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tspe_pkg::t_dp_status i_dp_status,
    input  logic                i_in_xfer,
    input  logic                i_out_busy,
    output tspe_pkg::t_uword    o_uword
);
    import tspe_pkg::*;

    // Program addresses
    localparam logic [PC_W-1:0] UA_IDLE      = 4'd0;
    localparam logic [PC_W-1:0] UA_CHK_RESET = 4'd1;
    localparam logic [PC_W-1:0] UA_CHK_FIRST = 4'd2;
    localparam logic [PC_W-1:0] UA_CHK_PRST  = 4'd3;
    localparam logic [PC_W-1:0] UA_FWD_TICK  = 4'd4;
    localparam logic [PC_W-1:0] UA_JB_CHECK  = 4'd5;
    localparam logic [PC_W-1:0] UA_JB_LOOP   = 4'd6;
    localparam logic [PC_W-1:0] UA_REPLAY    = 4'd7;
    localparam logic [PC_W-1:0] UA_MOVE      = 4'd8;
    localparam logic [PC_W-1:0] UA_RESET_POS = 4'd10;
    localparam logic [PC_W-1:0] UA_FIRST     = 4'd11;
    localparam logic [PC_W-1:0] UA_EMIT      = 4'd15;

    function automatic t_uword uw(input logic take, input logic emit, input t_dp_op op,
                                  input t_cond cond, input logic [PC_W-1:0] target);
        t_uword w;
        w.take   = take;
        w.emit   = emit;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // Program ROM; the emit word sits last so that pc+1 wraps to idle
    function automatic t_uword rom(input logic [PC_W-1:0] a);
        t_uword w;
        unique case (a)
            UA_IDLE:      w = uw(1'b1, 1'b0, DP_NOP,         C_NO_XFER,     UA_IDLE);
            UA_CHK_RESET: w = uw(1'b0, 1'b0, DP_NOP,         C_IS_RESET,    UA_RESET_POS);
            UA_CHK_FIRST: w = uw(1'b0, 1'b0, DP_NOP,         C_IS_FIRST,    UA_FIRST);
            UA_CHK_PRST:  w = uw(1'b0, 1'b0, DP_NOP,         C_WRAP_REQ,    UA_MOVE);
            UA_FWD_TICK:  w = uw(1'b0, 1'b0, DP_FWD_TICK,    C_FWD_HOLD,    UA_MOVE);
            UA_JB_CHECK:  w = uw(1'b0, 1'b0, DP_NOP,         C_JC_ZERO,     UA_REPLAY);
            UA_JB_LOOP:   w = uw(1'b0, 1'b0, DP_MOVE_REV,    C_JC_MORE,     UA_JB_LOOP);
            UA_REPLAY:    w = uw(1'b0, 1'b0, DP_REPLAY_TICK, C_REPLAY_HOLD, UA_EMIT);
            UA_MOVE:      w = uw(1'b0, 1'b0, DP_MOVE_FWD,    C_ALWAYS,      UA_EMIT);
            UA_RESET_POS: w = uw(1'b0, 1'b0, DP_RESET_POS,   C_ALWAYS,      UA_EMIT);
            UA_FIRST:     w = uw(1'b0, 1'b0, DP_CLR_FIRST,   C_ALWAYS,      UA_EMIT);
            UA_EMIT:      w = uw(1'b0, 1'b1, DP_NOP,         C_OUT_BUSY,    UA_EMIT);
            default:      w = uw(1'b0, 1'b0, DP_NOP,         C_ALWAYS,      UA_IDLE);
        endcase
        return w;
    endfunction

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          w_word;
    logic            w_jump;

    assign w_word  = rom(r_pc);
    assign o_uword = w_word;

    // Condition select
    always_comb begin
        unique case (w_word.cond)
            C_ALWAYS:      w_jump = 1'b1;
            C_NO_XFER:     w_jump = !i_in_xfer;
            C_IS_RESET:    w_jump = i_dp_status.is_reset;
            C_IS_FIRST:    w_jump = i_dp_status.is_first;
            C_WRAP_REQ:    w_jump = i_dp_status.wrap_req;
            C_FWD_HOLD:    w_jump = i_dp_status.fwd_hold;
            C_JC_ZERO:     w_jump = i_dp_status.jc_zero;
            C_JC_MORE:     w_jump = i_dp_status.jc_more;
            C_REPLAY_HOLD: w_jump = i_dp_status.replay_hold;
            C_OUT_BUSY:    w_jump = i_out_busy;
            default:       w_jump = 1'b1;
        endcase
    end

    assign n_pc = w_jump ? w_word.target : r_pc + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= UA_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== rtl/tspe_dpath.sv =====
module tspe_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tspe_pkg::t_cfg                i_cfg,
    input  tspe_pkg::t_uword              i_uword,
    input  logic                          i_load,
    input  logic                          i_opcode,
    input  logic                          i_wrap_req,
    input  logic [tspe_pkg::RND_W-1:0]    i_rnd_byte,
    input  logic                          i_rnd_dir,
    input  logic [tspe_pkg::POS_W-1:0]    i_rnd_step,
    output tspe_pkg::t_dp_status          o_status,
    output logic [tspe_pkg::POS_W-1:0]    o_step,
    output logic                          o_backward,
    output logic                          o_arp
);
    import tspe_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             bwd;
        logic             wrap;
    } t_move;

    // Latched item fields
    logic             r_opcode;
    logic             r_prst;
    logic [RND_W-1:0] r_rbyte;
    logic             r_rdir;
    logic [POS_W-1:0] r_rstep;

    // Track state
    logic [POS_W-1:0] r_pos;
    logic             r_bwd;
    logic             r_first;
    logic [CTR_W-1:0] r_fc;
    logic [CTR_W-1:0] r_rc;
    logic [POS_W-1:0] r_saved;
    logic [CNT_W-1:0] r_jc;
    logic             r_save;
    logic             r_arp;

    logic [CTR_W-1:0] w_fc_inc;
    logic [CTR_W-1:0] w_rc_inc;
    logic             w_rev;
    logic             w_mv_prst;
    t_move            w_mv;

    // Random step, raised to loop start then lowered to last step
    function automatic logic [POS_W-1:0] clamp_rnd(input logic [POS_W-1:0] v,
                                                    input t_cfg c);
        logic [POS_W-1:0] x;
        x = v;
        if (x < c.loop_start) x = c.loop_start;
        if (x > c.last_step)  x = c.last_step;
        return x;
    endfunction

    // One step under the direction-mode rule
    function automatic t_move move_one(input t_cfg c, input logic [POS_W-1:0] pos,
                                       input logic bwd, input logic rev, input logic prst,
                                       input logic [RND_W-1:0] rbyte, input logic rdir,
                                       input logic [POS_W-1:0] rstep);
        t_move m;
        logic  step_on;
        m.pos   = pos;
        m.bwd   = bwd;
        m.wrap  = 1'b0;
        step_on = 1'b1;
        unique case (c.mode)
            MODE_FWD:      m.bwd = 1'b0;
            MODE_BACK:     m.bwd = 1'b1;
            MODE_RND_DIR:  m.bwd = rdir;
            MODE_RND_STEP: begin
                m.pos   = clamp_rnd(rstep, c);
                step_on = 1'b0;
            end
            MODE_RND_MIX: begin
                if (rbyte < RND_MIX_HALF) begin
                    if (rbyte < RND_MIX_QUARTER) begin
                        m.bwd = rdir;
                    end else begin
                        m.pos   = clamp_rnd(rstep, c);
                        step_on = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        if (step_on) begin
            if (m.bwd ^ rev) begin
                if (prst || m.pos <= c.loop_start) begin
                    if (c.mode == MODE_PENDULUM) m.bwd = 1'b0;
                    else m.pos = c.last_step;
                    m.wrap = 1'b1;
                end else begin
                    m.pos = m.pos - 1'b1;
                    if (m.pos <= c.loop_start && c.mode == MODE_PINGPONG) m.bwd = 1'b0;
                end
            end else begin
                if (prst || m.pos >= c.last_step) begin
                    if (c.mode == MODE_PENDULUM) m.bwd = 1'b1;
                    else m.pos = c.loop_start;
                    m.wrap = 1'b1;
                end else begin
                    m.pos = m.pos + 1'b1;
                    if (m.pos >= c.last_step && c.mode == MODE_PINGPONG) m.bwd = 1'b1;
                end
            end
        end
        return m;
    endfunction

    // Shared move unit: reverse jump-back steps or the main step
    assign w_rev     = (i_uword.op == DP_MOVE_REV);
    assign w_mv_prst = w_rev ? 1'b0 : r_prst;
    assign w_mv      = move_one(i_cfg, r_pos, r_bwd, w_rev, w_mv_prst,
                                r_rbyte, r_rdir, r_rstep);

    assign w_fc_inc = r_fc + 1'b1;
    assign w_rc_inc = r_rc + 1'b1;

    // Flags for the sequencer
    assign o_status.is_reset    = r_opcode;
    assign o_status.is_first    = r_first;
    assign o_status.wrap_req    = r_prst;
    assign o_status.fwd_hold    = (w_fc_inc <= {1'b0, i_cfg.fwd_count});
    assign o_status.jc_zero     = (r_jc == '0);
    assign o_status.jc_more     = (r_jc != CNT_W'(1));
    assign o_status.replay_hold = (w_rc_inc <= {1'b0, i_cfg.rpl_count});

    assign o_step     = r_pos;
    assign o_backward = r_bwd;
    assign o_arp      = r_arp;

    // Item field capture
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_opcode <= i_opcode;
            r_prst   <= i_wrap_req;
            r_rbyte  <= i_rnd_byte;
            r_rdir   <= i_rnd_dir;
            r_rstep  <= i_rnd_step;
        end
    end

    // Track state update per control word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_bwd   <= 1'b0;
            r_first <= 1'b1;
            r_fc    <= '0;
            r_rc    <= '0;
            r_saved <= '0;
            r_jc    <= '0;
            r_save  <= 1'b0;
            r_arp   <= 1'b0;
        end else if (i_load) begin
            r_save <= 1'b0;
            r_arp  <= 1'b0;
        end else begin
            unique case (i_uword.op)
                DP_FWD_TICK: begin
                    if (w_fc_inc > {1'b0, i_cfg.fwd_count}) begin
                        r_fc <= '0;
                        r_jc <= i_cfg.jb_count;
                    end else begin
                        r_fc <= w_fc_inc;
                    end
                end
                DP_MOVE_REV: begin
                    r_pos <= w_mv.pos;
                    r_bwd <= w_mv.bwd;
                    r_arp <= r_arp | w_mv.wrap;
                    r_jc  <= r_jc - 1'b1;
                end
                DP_REPLAY_TICK: begin
                    if (w_rc_inc > {1'b0, i_cfg.rpl_count}) begin
                        r_rc   <= '0;
                        r_save <= 1'b1;
                    end else begin
                        r_rc  <= w_rc_inc;
                        r_pos <= r_saved;
                    end
                end
                DP_MOVE_FWD: begin
                    r_pos <= w_mv.pos;
                    r_bwd <= w_mv.bwd;
                    r_arp <= r_arp | w_mv.wrap;
                    if (r_save) r_saved <= w_mv.pos;
                end
                DP_RESET_POS: begin
                    r_first <= 1'b1;
                    r_fc    <= '0;
                    r_rc    <= '0;
                    r_arp   <= 1'b1;
                    if (i_cfg.mode == MODE_BACK) begin
                        r_bwd   <= 1'b1;
                        r_pos   <= i_cfg.last_step;
                        r_saved <= i_cfg.last_step;
                    end else begin
                        r_bwd   <= 1'b0;
                        r_pos   <= '0;
                        r_saved <= '0;
                    end
                end
                DP_CLR_FIRST: r_first <= 1'b0;
                default: ;
            endcase
        end
    end

    // The reverse loop only runs with steps left to take
    a_jb_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_uword.op == DP_MOVE_REV) |-> (r_jc != '0))
        else $error("reverse step with empty jump-back count");

    // A position reset leaves the saved step on the new position
    a_reset_saved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_uword.op == DP_RESET_POS && !i_load) |=> (r_first && r_saved == r_pos && r_arp))
        else $error("position reset left inconsistent state");

endmodule

// ===== rtl/track_step_position_engine.sv =====
// Channel | Dir | Fields
// s_axis  | in  | tuser: opcode; tdata: position_reset_request, random_byte,
//         |     |   random_direction, random_step
// m_axis  | out | tdata: current_step, moving_backward, arp_restart
// cfg     | in  | i_cfg_we / i_cfg_addr / i_cfg_data, one register per write
//
// One item at a time, run by a 16-word microprogram. After the input transfer the program
// checks for a reset item, then for the first advance after reset, then for a position
// reset request, which moves at once; otherwise it ticks the forward counter and moves,
// or on a progression event runs the jump-back loop, then replays the saved step or moves
// and saves the new one. The reverse jump-back loop steps back on the shared move unit.
// A full output register holds the program on its emit word; reset is synchronous.
module track_step_position_engine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] position_reset_request, [8:1] random_byte, [9] random_direction,
    // [15:10] random_step
    input  logic [15:0]                        s_axis_tdata,
    // [0] opcode
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [5:0] current_step, [6] moving_backward, [7] arp_restart
    output logic [7:0]                         m_axis_tdata,
    input  logic                               i_cfg_we,
    input  logic [tspe_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [tspe_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import tspe_pkg::*;

    t_cfg             r_cfg;
    t_uword           w_uword;
    t_dp_status       w_status;
    logic             w_in_xfer;
    logic             w_out_busy;
    logic             w_emit;
    logic [POS_W-1:0] w_step;
    logic             w_bwd;
    logic             w_arp;
    logic             r_m_valid;
    logic [7:0]       r_m_data;

    function automatic logic [POS_W-1:0] sat_step(input logic [POS_W-1:0] v);
        if (int'(v) > MAX_STEPS - 1) return POS_W'(MAX_STEPS - 1);
        return v;
    endfunction

    function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] v);
        if (int'(v) > MAX_PROGRESSION) return CNT_W'(MAX_PROGRESSION);
        return v;
    endfunction

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode       <= MODE_FWD;
            r_cfg.loop_start <= '0;
            r_cfg.last_step  <= LAST_STEP_RST;
            r_cfg.fwd_count  <= '0;
            r_cfg.jb_count   <= '0;
            r_cfg.rpl_count  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DIR_MODE:   r_cfg.mode       <= i_cfg_data[MODE_W-1:0];
                CFG_LOOP_START: r_cfg.loop_start <= sat_step(i_cfg_data[POS_W-1:0]);
                CFG_LAST_STEP:  r_cfg.last_step  <= sat_step(i_cfg_data[POS_W-1:0]);
                CFG_FWD_COUNT:  r_cfg.fwd_count  <= sat_cnt(i_cfg_data[CNT_W-1:0]);
                CFG_JB_COUNT:   r_cfg.jb_count   <= sat_cnt(i_cfg_data[CNT_W-1:0]);
                CFG_RPL_COUNT:  r_cfg.rpl_count  <= sat_cnt(i_cfg_data[CNT_W-1:0]);
                default: ;
            endcase
        end
    end

    // Handshake glue
    assign s_axis_tready = w_uword.take;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_busy    = r_m_valid && !m_axis_tready;
    assign w_emit        = w_uword.emit && !w_out_busy;

    tspe_useq u_useq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dp_status (w_status),
        .i_in_xfer   (w_in_xfer),
        .i_out_busy  (w_out_busy),
        .o_uword     (w_uword)
    );

    tspe_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_uword     (w_uword),
        .i_load      (w_in_xfer),
        .i_opcode    (s_axis_tuser),
        .i_wrap_req  (s_axis_tdata[0]),
        .i_rnd_byte  (s_axis_tdata[8:1]),
        .i_rnd_dir   (s_axis_tdata[9]),
        .i_rnd_step  (s_axis_tdata[15:10]),
        .o_status    (w_status),
        .o_step      (w_step),
        .o_backward  (w_bwd),
        .o_arp       (w_arp)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_emit) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) r_m_data <= {w_arp, w_bwd, w_step};
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // Only one item in flight: no new transfer right after one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // A result is only written into a free or draining output register
    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> m_axis_tvalid)
        else $error("result emitted but output not valid");

endmodule

// ===== test/track_step_position_engine_test.sv =====
module track_step_position_engine_test;
    import tspe_pkg::*;

    // Item opcodes carried on tuser
    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_RESET   = 1'b1;

    // Register indexes past the last register, expected to be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Mode code with no rule of its own
    localparam t_mode MODE_UNUSED = 3'd7;

    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 40;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 75;

    // One command, laid out as {tuser, tdata}
    typedef struct packed {
        logic             op;
        logic [POS_W-1:0] rnd_step;
        logic             rnd_dir;
        logic [RND_W-1:0] rnd_byte;
        logic             wrap_req;
    } t_cmd;

    // One position report, laid out as the output tdata
    typedef struct packed {
        logic             arp_restart;
        logic             backward;
        logic [POS_W-1:0] step;
    } t_pos;

    // Directed row: either a register write or a command, maybe with a fixed answer
    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_val;
        t_cmd                  cmd;
        logic                  pinned;
        t_pos                  pin;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Fixed answer for the command currently offered, if any
    logic pin_on = 1'b0;
    t_pos pin_val = '0;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int err_count = 0;
    int quiet_cycles = 0;

    t_pos pos_expected_q[$];

    // Track state as the engine should hold it
    t_cfg             cfg_m;
    logic [POS_W-1:0] pos_m;
    logic             bwd_m;
    logic             first_m;
    logic [CTR_W-1:0] fwd_ctr_m;
    logic [CTR_W-1:0] rpl_ctr_m;
    logic [POS_W-1:0] saved_m;

    track_step_position_engine i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Random step pulled into the loop region; last_step wins when bounds cross
    function automatic logic [POS_W-1:0] clamp_step(input logic [POS_W-1:0] r);
        logic [POS_W-1:0] v;
        v = r;
        if (v < cfg_m.loop_start) v = cfg_m.loop_start;
        if (v > cfg_m.last_step) v = cfg_m.last_step;
        return v;
    endfunction

    // One move under the direction rule, reversed when rev; returns 1 on a wrap
    function automatic logic move_once(input logic rev, input logic force_wrap,
                                       input t_cmd c);
        logic walk;
        logic wrapped;
        walk = 1'b1;
        wrapped = 1'b0;
        case (cfg_m.mode)
            MODE_FWD:     bwd_m = 1'b0;
            MODE_BACK:    bwd_m = 1'b1;
            MODE_RND_DIR: bwd_m = c.rnd_dir;
            MODE_RND_STEP: begin
                pos_m = clamp_step(c.rnd_step);
                walk = 1'b0;
            end
            MODE_RND_MIX: begin
                if (c.rnd_byte < RND_MIX_HALF) begin
                    if (c.rnd_byte < RND_MIX_QUARTER) begin
                        bwd_m = c.rnd_dir;
                    end else begin
                        pos_m = clamp_step(c.rnd_step);
                        walk = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        if (walk) begin
            if (bwd_m ^ rev) begin
                if (force_wrap || pos_m <= cfg_m.loop_start) begin
                    if (cfg_m.mode == MODE_PENDULUM) bwd_m = 1'b0;
                    else pos_m = cfg_m.last_step;
                    wrapped = 1'b1;
                end else begin
                    pos_m = pos_m - 1'b1;
                    if (pos_m <= cfg_m.loop_start && cfg_m.mode == MODE_PINGPONG) bwd_m = 1'b0;
                end
            end else begin
                if (force_wrap || pos_m >= cfg_m.last_step) begin
                    if (cfg_m.mode == MODE_PENDULUM) bwd_m = 1'b1;
                    else pos_m = cfg_m.loop_start;
                    wrapped = 1'b1;
                end else begin
                    pos_m = pos_m + 1'b1;
                    if (pos_m >= cfg_m.last_step && cfg_m.mode == MODE_PINGPONG) bwd_m = 1'b1;
                end
            end
        end
        return wrapped;
    endfunction

    // Next position report for one accepted command; updates the track state
    function automatic t_pos predict_position(input t_cmd c);
        t_pos r;
        logic keep_new;
        logic walk;
        int n;
        r = '0;
        keep_new = 1'b0;
        walk = 1'b1;
        if (c.op == OP_RESET) begin
            first_m = 1'b1;
            fwd_ctr_m = '0;
            rpl_ctr_m = '0;
            if (cfg_m.mode == MODE_BACK) begin
                bwd_m = 1'b1;
                pos_m = cfg_m.last_step;
            end else begin
                bwd_m = 1'b0;
                pos_m = '0;
            end
            saved_m = pos_m;
            r.arp_restart = 1'b1;
        end else if (first_m) begin
            first_m = 1'b0;
        end else begin
            // progression: count, jump back, then replay or save
            if (!c.wrap_req) begin
                fwd_ctr_m = fwd_ctr_m + 1'b1;
                if (fwd_ctr_m > cfg_m.fwd_count) begin
                    fwd_ctr_m = '0;
                    for (n = 0; n < cfg_m.jb_count; n++)
                        r.arp_restart |= move_once(1'b1, 1'b0, c);
                    rpl_ctr_m = rpl_ctr_m + 1'b1;
                    if (rpl_ctr_m > cfg_m.rpl_count) begin
                        rpl_ctr_m = '0;
                        keep_new = 1'b1;
                    end else begin
                        pos_m = saved_m;
                        walk = 1'b0;
                    end
                end
            end
            if (walk) r.arp_restart |= move_once(1'b0, c.wrap_req, c);
            if (keep_new) saved_m = pos_m;
        end
        r.step = pos_m;
        r.backward = bwd_m;
        return r;
    endfunction

    function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_DIR_MODE:   cfg_m.mode = val[MODE_W-1:0];
            CFG_LOOP_START: cfg_m.loop_start = val;
            CFG_LAST_STEP:  cfg_m.last_step = val;
            CFG_FWD_COUNT:  cfg_m.fwd_count = val[CNT_W-1:0];
            CFG_JB_COUNT:   cfg_m.jb_count = val[CNT_W-1:0];
            CFG_RPL_COUNT:  cfg_m.rpl_count = val[CNT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic t_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
        t_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.cfg_idx = idx;
        r.cfg_val = val;
        return r;
    endfunction

    function automatic t_row cmd_row(input logic op, input logic prst,
                                     input logic [RND_W-1:0] rb, input logic rd,
                                     input logic [POS_W-1:0] rs);
        t_row r;
        r = '0;
        r.cmd.op = op;
        r.cmd.wrap_req = prst;
        r.cmd.rnd_byte = rb;
        r.cmd.rnd_dir = rd;
        r.cmd.rnd_step = rs;
        return r;
    endfunction

    function automatic t_row pinned(input t_row r, input logic [POS_W-1:0] step,
                                    input logic bwd, input logic arp);
        t_row p;
        p = r;
        p.pinned = 1'b1;
        p.pin.step = step;
        p.pin.backward = bwd;
        p.pin.arp_restart = arp;
        return p;
    endfunction

    // Mostly random, with the two ends showing up often
    function automatic logic [CFG_DATA_W-1:0] pick_value(input int top);
        case ($urandom_range(3))
            0:       return '0;
            1:       return CFG_DATA_W'(top);
            default: return CFG_DATA_W'($urandom_range(top));
        endcase
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        c.op = ($urandom_range(99) < 8) ? OP_RESET : OP_ADVANCE;
        c.wrap_req = ($urandom_range(99) < 15);
        c.rnd_byte = RND_W'($urandom_range(255));
        c.rnd_dir = 1'($urandom_range(1));
        c.rnd_step = POS_W'($urandom_range(63));
        return c;
    endfunction

    task automatic report_error(input string what);
        err_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Write enable stays high until the next command goes out
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        apply_cfg(idx, val);
    endtask

    // Offer one command, with a random gap first, and wait for its transfer
    task automatic send_cmd(input t_cmd c, input logic pin_en, input t_pos pin);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_cfg_we <= 1'b0;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= c.op;
        s_axis_tdata <= {c.rnd_step, c.rnd_dir, c.rnd_byte, c.wrap_req};
        pin_on <= pin_en;
        pin_val <= pin;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop offering and wait for every outstanding report
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pos_expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_settings();
        logic [CFG_DATA_W-1:0] ls;
        logic [CFG_DATA_W-1:0] lst;
        ls = pick_value(63);
        if ($urandom_range(3) == 0) lst = pick_value(63);
        else lst = (ls > 53) ? 6'd63 : ls + CFG_DATA_W'($urandom_range(10));
        // mode sits in the low bits; the upper data bits are don't-care
        write_reg(CFG_DIR_MODE, CFG_DATA_W'($urandom_range(63)));
        write_reg(CFG_LOOP_START, ls);
        write_reg(CFG_LAST_STEP, lst);
        write_reg(CFG_FWD_COUNT, pick_value(15));
        write_reg(CFG_JB_COUNT, pick_value(15));
        write_reg(CFG_RPL_COUNT, pick_value(15));
        write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                  CFG_DATA_W'($urandom_range(63)));
    endtask

    // Receiver readiness
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Check reports against expectations, predict on command transfers, watchdog
    always @(posedge i_clk) begin : result_check
        t_pos got;
        t_pos want;
        t_pos pred;
        t_cmd acc;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (pos_expected_q.size() == 0) begin
                    report_error($sformatf("report %h with nothing expected", m_axis_tdata));
                end else begin
                    want = pos_expected_q.pop_front();
                    if (got.step !== want.step)
                        report_error($sformatf("current_step %0d, want %0d",
                                               got.step, want.step));
                    if (got.backward !== want.backward)
                        report_error($sformatf("moving_backward %b, want %b",
                                               got.backward, want.backward));
                    if (got.arp_restart !== want.arp_restart)
                        report_error($sformatf("arp_restart %b, want %b",
                                               got.arp_restart, want.arp_restart));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                acc = {s_axis_tuser, s_axis_tdata};
                pred = predict_position(acc);
                pos_expected_q.push_back(pin_on ? pin_val : pred);
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

    initial begin
        t_row plan[$];
        t_row row;
        int ph;
        int k;

        cfg_m.mode = MODE_FWD;
        cfg_m.loop_start = '0;
        cfg_m.last_step = LAST_STEP_RST;
        cfg_m.fwd_count = '0;
        cfg_m.jb_count = '0;
        cfg_m.rpl_count = '0;
        pos_m = '0;
        bwd_m = 1'b0;
        first_m = 1'b1;
        fwd_ctr_m = '0;
        rpl_ctr_m = '0;
        saved_m = '0;

        // Defaults after reset: forward, region 0..15, all counts zero
        plan.push_back(pinned(cmd_row(OP_ADVANCE, 1'b0, 8'h00, 1'b0, 6'd0), 6'd0, 1'b0, 1'b0));
        plan.push_back(cmd_row(OP_ADVANCE, 1'b0, 8'h00, 1'b0, 6'd0));
        plan.push_back(cmd_row(OP_ADVANCE, 1'b0, 8'hff, 1'b1, 6'd63));
        plan.push_back(pinned(cmd_row(OP_ADVANCE, 1'b1, 8'h00, 1'b0, 6'd0), 6'd0, 1'b0, 1'b1));
        plan.push_back(pinned(cmd_row(OP_RESET, 1'b1, 8'hff, 1'b1, 6'd63), 6'd0, 1'b0, 1'b1));
        // Backward: reset starts at last_step; first advance ignores the wrap request
        plan.push_back(cfg_row(CFG_DIR_MODE, 6'h39));
        plan.push_back(pinned(cmd_row(OP_RESET, 1'b0, 8'h00, 1'b0, 6'd0), 6'd15, 1'b1, 1'b1));
        plan.push_back(pinned(cmd_row(OP_ADVANCE, 1'b1, 8'h00, 1'b0, 6'd0), 6'd15, 1'b1, 1'b0));
        plan.push_back(cmd_row(OP_ADVANCE, 1'b0, 8'h12, 1'b0, 6'd5));
        // Ping-pong with jump-back and replay; reset lands below the loop start
        plan.push_back(cfg_row(CFG_DIR_MODE, CFG_DATA_W'(MODE_PINGPONG)));
        plan.push_back(cfg_row(CFG_LOOP_START, 6'd4));
        plan.push_back(cfg_row(CFG_LAST_STEP, 6'd7));
        plan.push_back(cfg_row(CFG_FWD_COUNT, 6'd1));
        plan.push_back(cfg_row(CFG_JB_COUNT, 6'd2));
        plan.push_back(cfg_row(CFG_RPL_COUNT, 6'd1));
        plan.push_back(pinned(cmd_row(OP_RESET, 1'b0, 8'h00, 1'b0, 6'd0), 6'd0, 1'b0, 1'b1));
        for (k = 0; k < 4; k++) plan.push_back(cmd_row(OP_ADVANCE, 1'b0, 8'h55, 1'b1, 6'd9));
        // Pendulum: the end step repeats as the direction turns
        plan.push_back(cfg_row(CFG_DIR_MODE, CFG_DATA_W'(MODE_PENDULUM)));
        plan.push_back(cfg_row(CFG_LOOP_START, 6'd0));
        plan.push_back(cfg_row(CFG_LAST_STEP, 6'd2));
        plan.push_back(cfg_row(CFG_FWD_COUNT, 6'd0));
        plan.push_back(cfg_row(CFG_JB_COUNT, 6'd0));
        plan.push_back(cfg_row(CFG_RPL_COUNT, 6'd0));
        plan.push_back(cfg_row(CFG_SPARE_LO, 6'h3f));
        plan.push_back(cfg_row(CFG_SPARE_HI, 6'h3f));
        plan.push_back(pinned(cmd_row(OP_RESET, 1'b0, 8'h00, 1'b0, 6'd0), 6'd0, 1'b0, 1'b1));
        plan.push_back(pinned(cmd_row(OP_ADVANCE, 1'b0, 8'h00, 1'b0, 6'd0), 6'd0, 1'b0, 1'b0));
        for (k = 0; k < 3; k++) plan.push_back(cmd_row(OP_ADVANCE, 1'b0, 8'h00, 1'b0, 6'd0));
        // Random step with crossed bounds: clamps to last_step
        plan.push_back(cfg_row(CFG_DIR_MODE, CFG_DATA_W'(MODE_RND_STEP)));
        plan.push_back(cfg_row(CFG_LOOP_START, 6'd40));
        plan.push_back(cfg_row(CFG_LAST_STEP, 6'd20));
        plan.push_back(cmd_row(OP_ADVANCE, 1'b0, 8'h00, 1'b0, 6'd0));
        plan.push_back(cmd_row(OP_ADVANCE, 1'b0, 8'hff, 1'b1, 6'd63));
        // Mixed random: direction quarter, jump quarter, normal half
        plan.push_back(cfg_row(CFG_DIR_MODE, CFG_DATA_W'(MODE_RND_MIX)));
        plan.push_back(cfg_row(CFG_LOOP_START, 6'd0));
        plan.push_back(cfg_row(CFG_LAST_STEP, 6'd63));
        plan.push_back(cfg_row(CFG_JB_COUNT, 6'd1));
        plan.push_back(cmd_row(OP_ADVANCE, 1'b0, 8'h3f, 1'b1, 6'd10));
        plan.push_back(cmd_row(OP_ADVANCE, 1'b0, 8'h40, 1'b0, 6'd33));
        plan.push_back(cmd_row(OP_ADVANCE, 1'b0, 8'hff, 1'b1, 6'd2));
        // Unused mode: plain move along the current direction
        plan.push_back(cfg_row(CFG_DIR_MODE, CFG_DATA_W'(MODE_UNUSED)));
        plan.push_back(cmd_row(OP_ADVANCE, 1'b0, 8'h00, 1'b0, 6'd0));
        plan.push_back(cmd_row(OP_ADVANCE, 1'b1, 8'h00, 1'b0, 6'd0));
        // Random direction with every count at its top and a one-step region at the top
        plan.push_back(cfg_row(CFG_DIR_MODE, CFG_DATA_W'(MODE_RND_DIR)));
        plan.push_back(cfg_row(CFG_LOOP_START, 6'd63));
        plan.push_back(cfg_row(CFG_FWD_COUNT, 6'd15));
        plan.push_back(cfg_row(CFG_JB_COUNT, 6'd15));
        plan.push_back(cfg_row(CFG_RPL_COUNT, 6'd15));
        plan.push_back(cmd_row(OP_ADVANCE, 1'b0, 8'h00, 1'b1, 6'd0));
        plan.push_back(cmd_row(OP_ADVANCE, 1'b0, 8'h00, 1'b0, 6'd0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part
        tx_idle_pct = 13;
        rx_stall_pct = 13;
        for (k = 0; k < plan.size(); k++) begin
            row = plan[k];
            if (row.is_cfg) begin
                drain_results();
                write_reg(row.cfg_idx, row.cfg_val);
            end else begin
                send_cmd(row.cmd, row.pinned, row.pin);
            end
        end

        // Random part: new settings each phase, idling profile rotating
        for (ph = 0; ph < PHASES; ph++) begin
            drain_results();
            case (ph % 4)
                0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct = 76;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 76;
                end
                default: begin
                    tx_idle_pct = 13;
                    rx_stall_pct = 13;
                end
            endcase
            random_settings();
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // hold the sender until the pipeline is empty
                if (k == PHASE_ITEMS / 2 && ph[0]) drain_results();
                send_cmd(random_cmd(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
